### hdl/aac_pkg.sv
// aac_pkg: shared types and constants of the analog axis conditioner
// used by aac_divider, aac_tracker and analog_axis_conditioner
package aac_pkg;

  localparam int DEF_FULL_SCALE_MV = 3600;
  localparam int DEF_RESOLUTION    = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 16;
  localparam int REPORT_W   = 18;
  localparam int PROD_W     = 32;
  localparam int DIV_CNT_W  = $clog2(PROD_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER    = 3'd0,
    REG_DEADZONE  = 3'd1,
    REG_LIMIT     = 3'd2,
    REG_MODE      = 3'd3,
    REG_SCALE_MUL = 3'd4,
    REG_SCALE_DIV = 3'd5,
    REG_THRESHOLD = 3'd6,
    REG_SETTLE    = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_CENTER,
    S_DEAD,
    S_LIMIT,
    S_INV,
    S_SCALE,
    S_DSTART,
    S_DIV,
    S_FIX,
    S_TRACK,
    S_REPORT
  } seq_state_t;

  // sequencer strobes to the tracker
  typedef struct packed {
    logic update;
    logic decide;
  } trk_ctrl_t;

  // report decision for the current sample
  typedef struct packed {
    logic                       report;
    logic signed [REPORT_W-1:0] value;
    logic                       idle;
  } trk_result_t;

endpackage

### hdl/analog_axis_conditioner.sv
// analog_axis_conditioner: top level, sequencer, shared multiplier and config registers
// instantiates aac_divider and aac_tracker; depends on aac_pkg
//
// one analog channel: each request on s_axis carries one adc sample in
// s_axis_tdata[15:0] (signed). the sample is converted to millivolts,
// centered, deadzoned, clamped, optionally inverted and scaled, then tracked
// in change-only, accumulate or settle mode. every sample gives exactly one
// request on m_axis: report value in tdata, report flag and idle flag in tuser.
// configuration registers are written over cfg_valid/cfg_index/cfg_data,
// always accepted; write them only while no sample is in flight.
// one sample at a time: s_axis_tready is high only while the sequencer is idle.
// the path from input request to output valid is dominated by the 32-step
// restoring divider; a new sample is taken only once the sequencer is back in idle.
// one multiplier is shared by the millivolt conversion and
// the scale step. the result sits in an output register, so the next sample
// is already accepted and processed while a stalled result waits; only the
// final report step waits for the output register to drain.
// reset clears the sequencer, tracking state and output valid and restores
// register defaults (scale 1/1, everything else zero).
module analog_axis_conditioner
  import aac_pkg::*;
#(
  parameter int FULL_SCALE_MV = DEF_FULL_SCALE_MV,
  parameter int RESOLUTION    = DEF_RESOLUTION
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] raw_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [17:0] report_value, [23:18] zero
  output logic [1:0]            m_axis_tuser,   // [0] report_valid, [1] channel_idle
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [VALUE_W-1:0] FS_MV = VALUE_W'(FULL_SCALE_MV);

  // configuration registers
  logic [14:0]        center_mv;
  logic [14:0]        deadzone_mv;
  logic [15:0]        limit_mv;
  logic [1:0]         mode_bits;
  logic [15:0]        scale_mul;
  logic [15:0]        scale_div;
  logic [15:0]        change_threshold;
  logic [15:0]        settle_count;

  seq_state_t         state, state_next;
  trk_ctrl_t          trk_ctrl;
  trk_result_t        trk_res;

  logic [14:0]               raw_floor;
  logic signed [VALUE_W-1:0] vreg;
  logic                      neg;
  logic [VALUE_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]         mul_q;
  logic                      div_start, div_done;
  logic [VALUE_W-1:0]        div_q;
  logic [VALUE_W-1:0]        divisor;

  logic                       out_free;
  logic                       out_report;
  logic signed [REPORT_W-1:0] out_value;
  logic                       out_idle;

  logic signed [VALUE_W:0]   v_ext, dz_ext, lim_ext;
  logic signed [VALUE_W:0]   dz_sub, dz_add;
  logic signed [VALUE_W-1:0] dz_res, lim_res;
  logic [VALUE_W-1:0]        vmag;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign divisor       = (scale_div == '0) ? VALUE_W'(1) : scale_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_mv        <= '0;
      deadzone_mv      <= '0;
      limit_mv         <= '0;
      mode_bits        <= '0;
      scale_mul        <= 16'd1;
      scale_div        <= 16'd1;
      change_threshold <= '0;
      settle_count     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER:    center_mv        <= cfg_data[14:0];
        REG_DEADZONE:  deadzone_mv      <= cfg_data[14:0];
        REG_LIMIT:     limit_mv         <= cfg_data;
        REG_MODE:      mode_bits        <= cfg_data[1:0];
        REG_SCALE_MUL: scale_mul        <= cfg_data;
        REG_SCALE_DIV: scale_div        <= cfg_data;
        REG_THRESHOLD: change_threshold <= cfg_data;
        REG_SETTLE:    settle_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_axis_tvalid) state_next = S_CONV;
      S_CONV:   state_next = S_CENTER;
      S_CENTER: state_next = S_DEAD;
      S_DEAD:   state_next = S_LIMIT;
      S_LIMIT:  state_next = S_INV;
      S_INV:    state_next = S_SCALE;
      S_SCALE:  state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_FIX;
      S_FIX:    state_next = S_TRACK;
      S_TRACK:  state_next = S_REPORT;
      S_REPORT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    div_start       = 1'b0;
    trk_ctrl.update = 1'b0;
    trk_ctrl.decide = 1'b0;
    mul_a           = {1'b0, raw_floor};
    mul_b           = FS_MV;
    case (state)
      S_SCALE: begin
        mul_a = vmag;
        mul_b = scale_mul;
      end
      S_DSTART: div_start = 1'b1;
      S_TRACK:  trk_ctrl.update = 1'b1;
      S_REPORT: trk_ctrl.decide = out_free;
      default: ;
    endcase
  end

  // conditioning datapath
  assign v_ext   = (VALUE_W+1)'(vreg);
  assign dz_ext  = {2'b00, deadzone_mv};
  assign lim_ext = {1'b0, limit_mv};
  assign dz_sub  = v_ext - dz_ext;
  assign dz_add  = v_ext + dz_ext;
  assign vmag    = vreg[VALUE_W-1] ? VALUE_W'(-vreg) : VALUE_W'(vreg);

  always_comb begin
    dz_res = vreg;
    if (deadzone_mv != '0) begin
      if (v_ext > 0) begin
        dz_res = dz_sub[VALUE_W] ? '0 : dz_sub[VALUE_W-1:0];
      end else if (v_ext < 0) begin
        dz_res = (dz_add > 0) ? '0 : dz_add[VALUE_W-1:0];
      end
    end
  end

  always_comb begin
    lim_res = vreg;
    if (limit_mv != '0) begin
      if (v_ext > lim_ext) begin
        lim_res = lim_ext[VALUE_W-1:0];
      end else if (v_ext < -lim_ext) begin
        lim_res = VALUE_W'(-lim_ext);
      end
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    if (state == S_CONV || state == S_SCALE) begin
      mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:   raw_floor <= s_axis_tdata[15] ? '0 : s_axis_tdata[14:0];
      S_CENTER: vreg <= mul_q[RESOLUTION +: VALUE_W] - {1'b0, center_mv};
      S_DEAD:   vreg <= dz_res;
      S_LIMIT:  vreg <= lim_res;
      S_INV:    if (mode_bits[1]) vreg <= -vreg;
      S_SCALE:  neg <= vreg[VALUE_W-1];
      S_FIX:    vreg <= neg ? VALUE_W'(-div_q) : div_q;
      default: ;
    endcase
  end

  aac_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_q),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  aac_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (trk_ctrl),
    .value        (vreg),
    .change_only  (mode_bits[0]),
    .threshold    (change_threshold),
    .settle_count (settle_count),
    .result       (trk_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (trk_ctrl.decide) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (trk_ctrl.decide) begin
      out_report <= trk_res.report;
      out_value  <= trk_res.value;
      out_idle   <= trk_res.idle;
    end
  end

  assign m_axis_tdata = {6'b000000, out_value};
  assign m_axis_tuser = {out_idle, out_report};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("sequencer still ready after taking a sample");

  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_REPORT))
    else $error("output valid raised outside the report step");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[17:0] == '0))
    else $error("nonzero value without a report");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

endmodule

### hdl/aac_divider.sv
// aac_divider: restoring divider, one quotient bit per cycle
// unsigned 32-bit dividend by 16-bit divisor; depends on aac_pkg
module aac_divider
  import aac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PROD_W-1:0]   dividend,
  input  logic [VALUE_W-1:0]  divisor,
  output logic                done,
  output logic [VALUE_W-1:0]  quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    work;
  logic [VALUE_W-1:0]   rem;
  logic [VALUE_W-1:0]   dsr;
  logic [VALUE_W:0]     rem_sh;
  logic [VALUE_W+1:0]   diff;

  // shift in the next dividend bit and try a subtract
  assign rem_sh = {rem, work[PROD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      if (!diff[VALUE_W+1]) begin
        rem  <= diff[VALUE_W-1:0];
        work <= {work[PROD_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[VALUE_W-1:0];
        work <= {work[PROD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = work[VALUE_W-1:0];

endmodule

### hdl/aac_tracker.sv
// aac_tracker: change-only, accumulate and settle tracking plus report decision
// holds pending value, last report, anchor, quiet run and idle flag; depends on aac_pkg
module aac_tracker
  import aac_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  trk_ctrl_t                  ctrl,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic                       change_only,
  input  logic [VALUE_W-1:0]         threshold,
  input  logic [VALUE_W-1:0]         settle_count,
  output trk_result_t                result
);

  logic signed [REPORT_W-1:0] pending, pending_next;
  logic signed [VALUE_W-1:0]  last_reported;
  logic signed [VALUE_W-1:0]  anchor, anchor_next;
  logic [VALUE_W-1:0]         quiet_run, quiet_run_next;
  logic                       idle_flag, idle_next;

  logic                       settle_cfg;
  logic signed [VALUE_W:0]    anchor_diff;
  logic [VALUE_W:0]           anchor_mag;
  logic [VALUE_W-1:0]         quiet_inc;
  logic signed [REPORT_W-1:0] value_ext;
  logic signed [REPORT_W-1:0] last_ext;
  logic signed [REPORT_W:0]   report_diff;
  logic [REPORT_W:0]          report_mag;
  logic                       report;

  assign settle_cfg = (threshold != '0) && (settle_count != '0);
  assign value_ext  = REPORT_W'(value);
  assign last_ext   = REPORT_W'(last_reported);

  // update step
  assign anchor_diff = (VALUE_W+1)'(value) - (VALUE_W+1)'(anchor);
  assign anchor_mag  = anchor_diff[VALUE_W] ? (VALUE_W+1)'(-anchor_diff)
                                            : (VALUE_W+1)'(anchor_diff);
  assign quiet_inc   = quiet_run + 1'b1;

  always_comb begin
    anchor_next    = anchor;
    quiet_run_next = quiet_run;
    idle_next      = idle_flag;
    if (change_only) begin
      if (settle_cfg) begin
        if (anchor_mag >= {1'b0, threshold}) begin
          anchor_next    = value;
          quiet_run_next = '0;
          idle_next      = 1'b0;
        end else if (!idle_flag) begin
          quiet_run_next = quiet_inc;
          idle_next      = (quiet_inc >= settle_count);
        end
        pending_next = idle_next ? last_ext : value_ext;
      end else begin
        pending_next = value_ext;
      end
    end else begin
      // accumulator wraps at 18 bits
      pending_next = pending + value_ext;
    end
  end

  // decision step
  assign report_diff = (REPORT_W+1)'(pending) - (REPORT_W+1)'(last_ext);
  assign report_mag  = report_diff[REPORT_W] ? (REPORT_W+1)'(-report_diff)
                                             : (REPORT_W+1)'(report_diff);

  always_comb begin
    if (threshold != '0 && !settle_cfg) begin
      report = report_mag >= (REPORT_W+1)'(threshold);
    end else begin
      report = pending != last_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= '0;
      last_reported <= '0;
      anchor        <= '0;
      quiet_run     <= '0;
      idle_flag     <= 1'b0;
    end else if (ctrl.update) begin
      pending   <= pending_next;
      anchor    <= anchor_next;
      quiet_run <= quiet_run_next;
      idle_flag <= idle_next;
    end else if (ctrl.decide && report) begin
      pending <= '0;
      if (change_only) begin
        last_reported <= pending[VALUE_W-1:0];
      end
    end
  end

  assign result.report = report;
  assign result.value  = report ? pending : '0;
  assign result.idle   = idle_flag;

endmodule

### sim/tb_analog_axis_conditioner.sv
// tb_analog_axis_conditioner: self-checking bench for the analog axis conditioner
// a table of directed samples and register writes, then randomized phases checked
// against an in-bench model of conditioning and tracking; depends on aac_pkg
module tb_analog_axis_conditioner;
  import aac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_MV     = DEF_FULL_SCALE_MV;
  localparam int RES_BITS    = DEF_RESOLUTION;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;

  localparam logic [1:0] MODE_ACCUM  = 2'b00;
  localparam logic [1:0] MODE_CHANGE = 2'b01;
  localparam logic [1:0] MODE_INVERT = 2'b10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  analog_axis_conditioner u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register image
  logic [14:0] c_center   = '0;
  logic [14:0] c_deadzone = '0;
  logic [15:0] c_limit    = '0;
  logic [1:0]  c_mode     = MODE_ACCUM;
  logic [15:0] c_mul      = 16'd1;
  logic [15:0] c_div      = 16'd1;
  logic [15:0] c_thr      = '0;
  logic [15:0] c_settle   = '0;

  // tracking state
  int          pend_acc  = 0;
  int          last_rep  = 0;
  int          anchor_mv = 0;
  logic [15:0] quiet_cnt = '0;
  bit          is_idle   = 1'b0;

  trk_result_t expected_reports[$];

  int errors = 0, samples_sent = 0, results_checked = 0;
  int reports_seen = 0, idle_seen = 0, cfg_writes = 0;
  int cycle_count = 0;
  int send_gap_pct = 0, recv_gap_pct = 0;
  bit long_hold_req = 1'b0;

  typedef struct {
    bit          is_write;
    cfg_reg_t    reg_idx;
    logic [15:0] word;
    bit          has_want;
    trk_result_t want;
  } step_row_t;

  step_row_t dir_rows[$];

  function automatic int sx16(int x);
    logic signed [15:0] t;
    t = x[15:0];
    return t;
  endfunction

  function automatic int sx18(int x);
    logic signed [17:0] t;
    t = x[17:0];
    return t;
  endfunction

  function automatic int iabs(int x);
    return (x < 0) ? -x : x;
  endfunction

  // millivolts, centered, deadzoned, clamped, inverted and scaled
  function automatic int condition_sample(logic [15:0] raw);
    int mv, v, dz, lim, num, den;
    mv = ($signed(raw) < 0) ? 0 : ((int'(raw) * FULL_MV) >> RES_BITS);
    v = sx16(mv - int'(c_center));
    dz = c_deadzone;
    if (dz != 0) begin
      if (v > 0) v = (v < dz) ? 0 : v - dz;
      if (v < 0) v = (v > -dz) ? 0 : v + dz;
    end
    lim = c_limit;
    if (lim != 0) begin
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
    end
    if (c_mode[1]) v = sx16(-v);
    num = c_mul;
    den = c_div;
    if (den == 0) den = 1;
    return sx16((v * num) / den);
  endfunction

  function automatic trk_result_t track_sample(logic [15:0] raw);
    int v, thr_i;
    bit settle_on, fire;
    trk_result_t r;
    v = condition_sample(raw);
    thr_i = c_thr;
    settle_on = (c_thr != 0) && (c_settle != 0);
    if (c_mode[0]) begin
      if (settle_on) begin
        if (iabs(v - anchor_mv) >= thr_i) begin
          anchor_mv = v;
          quiet_cnt = '0;
          is_idle = 1'b0;
        end else if (!is_idle) begin
          quiet_cnt = quiet_cnt + 16'd1;
          if (quiet_cnt >= c_settle) is_idle = 1'b1;
        end
        pend_acc = is_idle ? last_rep : v;
      end else begin
        pend_acc = v;
      end
    end else begin
      pend_acc = sx18(pend_acc + v);
    end
    if (!settle_on && thr_i != 0) fire = iabs(pend_acc - last_rep) >= thr_i;
    else fire = pend_acc != last_rep;
    r.report = fire;
    r.value = fire ? pend_acc[17:0] : '0;
    r.idle = is_idle;
    if (fire) begin
      if (c_mode[0]) last_rep = sx16(pend_acc);
      pend_acc = 0;
    end
    return r;
  endfunction

  function automatic step_row_t cfg_row(cfg_reg_t idx, logic [15:0] d);
    step_row_t s;
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.word = d;
    s.has_want = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_row_t sample_row(logic [15:0] raw);
    step_row_t s;
    s = cfg_row(REG_CENTER, raw);
    s.is_write = 1'b0;
    return s;
  endfunction

  function automatic step_row_t known_row(logic [15:0] raw, bit rep, int val, bit idle);
    step_row_t s;
    s = sample_row(raw);
    s.has_want = 1'b1;
    s.want.report = rep;
    s.want.value = val[17:0];
    s.want.idle = idle;
    return s;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_CENTER:    c_center = d[14:0];
      REG_DEADZONE:  c_deadzone = d[14:0];
      REG_LIMIT:     c_limit = d;
      REG_MODE:      c_mode = d[1:0];
      REG_SCALE_MUL: c_mul = d;
      REG_SCALE_DIV: c_div = d;
      REG_THRESHOLD: c_thr = d;
      REG_SETTLE:    c_settle = d;
      default: ;
    endcase
  endtask

  // leaves tvalid high so the next request can follow back to back
  task automatic send_sample(logic [15:0] raw, bit has_want, trk_result_t want);
    trk_result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= raw;
    do @(posedge clk); while (!s_axis_tready);
    r = track_sample(raw);
    expected_reports.push_back(has_want ? want : r);
    samples_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic sender_gap;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic pick_settings(bit settle_bias);
    logic [15:0] m, dv, th, st, md;
    case ($urandom_range(0, 5))
      0: m = 16'd0;
      1: m = 16'hFFFF;
      2: m = 16'($urandom_range(0, 65535));
      default: m = 16'd1;
    endcase
    case ($urandom_range(0, 5))
      0: dv = 16'd0;
      1: dv = 16'hFFFF;
      2: dv = 16'($urandom_range(1, 65535));
      3: dv = 16'($urandom_range(1, 16));
      default: dv = 16'd1;
    endcase
    case ($urandom_range(0, 5))
      0: th = 16'd0;
      1: th = 16'hFFFF;
      2: th = 16'($urandom_range(0, 65535));
      default: th = 16'($urandom_range(1, 500));
    endcase
    case ($urandom_range(0, 3))
      0: st = 16'd0;
      1: st = 16'hFFFF;
      default: st = 16'($urandom_range(1, 10));
    endcase
    md = 16'($urandom_range(0, 65535));
    if (settle_bias) begin
      m = 16'd1;
      dv = 16'd1;
      th = 16'($urandom_range(20, 500));
      st = 16'($urandom_range(1, 8));
      md = md | 16'(MODE_CHANGE);
    end
    case ($urandom_range(0, 4))
      0: write_reg(REG_CENTER, 16'd0);
      1: write_reg(REG_CENTER, 16'h7FFF);
      // upper bit is outside the register and must be dropped
      2: write_reg(REG_CENTER, 16'h8000 | 16'($urandom_range(0, 32767)));
      default: write_reg(REG_CENTER, 16'($urandom_range(0, 28800)));
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: write_reg(REG_DEADZONE, 16'd0);
      3: write_reg(REG_DEADZONE, 16'h7FFF);
      4: write_reg(REG_DEADZONE, 16'($urandom_range(0, 65535)));
      default: write_reg(REG_DEADZONE, 16'($urandom_range(1, 2000)));
    endcase
    case ($urandom_range(0, 5))
      0, 1: write_reg(REG_LIMIT, 16'd0);
      2: write_reg(REG_LIMIT, 16'hFFFF);
      default: write_reg(REG_LIMIT, 16'($urandom_range(1, 20000)));
    endcase
    write_reg(REG_MODE, md);
    write_reg(REG_SCALE_MUL, m);
    write_reg(REG_SCALE_DIV, dv);
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_SETTLE, st);
  endtask

  // output side: check each result, then decide next tready
  initial begin
    trk_result_t want;
    int hold_cnt, stall_left;
    hold_cnt = 0;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result with no sample outstanding: tuser %b tdata %h",
                 m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          results_checked++;
          if (m_axis_tuser[0]) reports_seen++;
          if (m_axis_tuser[1]) idle_seen++;
          if (m_axis_tuser[0] !== want.report) begin
            $error("report_valid: expected %0d, got %0d", want.report, m_axis_tuser[0]);
            errors++;
          end
          if ($signed(m_axis_tdata[17:0]) !== want.value) begin
            $error("report_value: expected %0d, got %0d", want.value,
                   $signed(m_axis_tdata[17:0]));
            errors++;
          end
          if (m_axis_tuser[1] !== want.idle) begin
            $error("channel_idle: expected %0d, got %0d", want.idle, m_axis_tuser[1]);
            errors++;
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
        stall_left = $urandom_range(1, 13) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL analog_axis_conditioner");
      $finish;
    end
  end

  initial begin
    logic [15:0] base, raw;
    int r;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CENTER;
    cfg_data = '0;

    // reset defaults: accumulate, no threshold, unit scale
    dir_rows.push_back(known_row(16'h0000, 1'b0, 0, 1'b0));
    dir_rows.push_back(known_row(16'h8000, 1'b0, 0, 1'b0));
    dir_rows.push_back(known_row(16'h7FFF, 1'b1, 28799, 1'b0));
    dir_rows.push_back(known_row(16'h1000, 1'b1, 3600, 1'b0));
    dir_rows.push_back(known_row(16'hFFFF, 1'b0, 0, 1'b0));
    // change-only reporting
    dir_rows.push_back(cfg_row(REG_MODE, 16'(MODE_CHANGE)));
    dir_rows.push_back(known_row(16'h1000, 1'b1, 3600, 1'b0));
    dir_rows.push_back(known_row(16'h1000, 1'b0, 0, 1'b0));
    dir_rows.push_back(cfg_row(REG_CENTER, 16'h7FFF));
    dir_rows.push_back(known_row(16'h0000, 1'b1, -32767, 1'b0));
    // deadzone and clamp around mid scale
    dir_rows.push_back(cfg_row(REG_CENTER, 16'd14400));
    dir_rows.push_back(cfg_row(REG_DEADZONE, 16'd500));
    dir_rows.push_back(sample_row(16'd16612));
    dir_rows.push_back(sample_row(16'h7FFF));
    dir_rows.push_back(sample_row(16'h0000));
    dir_rows.push_back(cfg_row(REG_LIMIT, 16'd1000));
    dir_rows.push_back(sample_row(16'h0000));
    dir_rows.push_back(sample_row(16'h7FFF));
    dir_rows.push_back(cfg_row(REG_MODE, 16'(MODE_CHANGE | MODE_INVERT)));
    dir_rows.push_back(sample_row(16'h7FFF));
    dir_rows.push_back(cfg_row(REG_DEADZONE, 16'h7FFF));
    dir_rows.push_back(sample_row(16'h7FFF));
    // scale overflow, zero divisor, large divisor, zero multiplier
    dir_rows.push_back(cfg_row(REG_DEADZONE, 16'd0));
    dir_rows.push_back(cfg_row(REG_LIMIT, 16'hFFFF));
    dir_rows.push_back(cfg_row(REG_CENTER, 16'd0));
    dir_rows.push_back(cfg_row(REG_MODE, 16'(MODE_CHANGE)));
    dir_rows.push_back(cfg_row(REG_SCALE_MUL, 16'hFFFF));
    dir_rows.push_back(sample_row(16'h7FFF));
    dir_rows.push_back(cfg_row(REG_SCALE_DIV, 16'd0));
    dir_rows.push_back(sample_row(16'h1000));
    dir_rows.push_back(cfg_row(REG_SCALE_MUL, 16'd3));
    dir_rows.push_back(cfg_row(REG_SCALE_DIV, 16'hFFFF));
    dir_rows.push_back(sample_row(16'h7FFF));
    dir_rows.push_back(cfg_row(REG_SCALE_MUL, 16'd0));
    dir_rows.push_back(sample_row(16'h7FFF));
    // settle: quiet samples go idle, a jump wakes the channel
    dir_rows.push_back(cfg_row(REG_SCALE_MUL, 16'd1));
    dir_rows.push_back(cfg_row(REG_SCALE_DIV, 16'd1));
    dir_rows.push_back(cfg_row(REG_THRESHOLD, 16'd100));
    dir_rows.push_back(cfg_row(REG_SETTLE, 16'd2));
    dir_rows.push_back(sample_row(16'h1000));
    dir_rows.push_back(sample_row(16'h1010));
    dir_rows.push_back(sample_row(16'h1010));
    dir_rows.push_back(sample_row(16'h1000));
    dir_rows.push_back(sample_row(16'h7FFF));
    // settle band set while accumulating
    dir_rows.push_back(cfg_row(REG_THRESHOLD, 16'hFFFF));
    dir_rows.push_back(cfg_row(REG_SETTLE, 16'hFFFF));
    dir_rows.push_back(cfg_row(REG_MODE, 16'(MODE_ACCUM)));
    dir_rows.push_back(sample_row(16'h1000));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].word);
      end else begin
        send_sample(dir_rows[i].word, dir_rows[i].has_want, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      pick_settings(ph % 3 == 1);
      if (ph == 2 || ph == PHASES - 1) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end else begin
        send_gap_pct = $urandom_range(5, 40);
        recv_gap_pct = $urandom_range(5, 40);
      end
      base = 16'($urandom_range(0, 65535));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sender_gap();
        r = $urandom_range(0, 9);
        // mostly a jittering level so settle and change-only get exercised
        if (r <= 5) begin
          raw = base + 16'($urandom_range(0, 40)) - 16'd20;
        end else if (r == 6) begin
          base = 16'($urandom_range(0, 65535));
          raw = base;
        end else begin
          raw = 16'($urandom_range(0, 65535));
        end
        send_sample(raw, 1'b0, '0);
        if (ph == 3 && i == 20) long_hold_req = 1'b1;
        if (ph == 5 && i == 50) drain();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("%0d samples sent, %0d results checked, %0d config writes",
             samples_sent, results_checked, cfg_writes);
    $display("%0d results carried a report, %0d flagged the channel idle",
             reports_seen, idle_seen);
    if (errors == 0) begin
      $display("PASS analog_axis_conditioner");
    end else begin
      $display("FAIL analog_axis_conditioner");
    end
    $finish;
  end

endmodule
